[hw/rtl/encoder_pll_tracker_top_macros.svh]
// Assertion macros used by the encoder tracker top level.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ENCODER_PLL_TRACKER_TOP_MACROS_SVH
`define ENCODER_PLL_TRACKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/epll_pkg.sv]
// Shared types, register map and helper functions of the encoder tracker.
// No dependencies; used by epll_mod and encoder_pll_tracker_top.
package epll_pkg;

    // Width of the signed value handed to the turn remainder unit.
    localparam int DVD_W = 32;

    // Configuration port address width (six 32-bit registers).
    localparam int ADDR_W = 5;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_PROP_GAIN    = 3'd0;
    localparam reg_idx_t REG_INTEG_GAIN   = 3'd1;
    localparam reg_idx_t REG_VEL_LIMIT    = 3'd2;
    localparam reg_idx_t REG_FILTER_ALPHA = 3'd3;
    localparam reg_idx_t REG_RELOCK_ERR   = 3'd4;
    localparam reg_idx_t REG_RELOCK_STEP  = 3'd5;

    localparam logic [13:0] RELOCK_ERR_RST  = 14'd2608;
    localparam logic [13:0] RELOCK_STEP_RST = 14'd261;

    // Which gain feeds the shared multiplier.
    typedef logic [1:0] mstep_t;

    localparam mstep_t MS_INTEG = 2'd0;
    localparam mstep_t MS_PROP  = 2'd1;
    localparam mstep_t MS_ALPHA = 2'd2;

    // Saturate a 48-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < 48'shFFFF_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/epll_mod.sv]
// Remainder of a signed 32-bit value modulo the encoder turn count.
// Depends on epll_pkg. A mask for a power-of-two turn, else one bit per cycle.
module epll_mod
    import epll_pkg::*;
#(
    parameter int unsigned COUNTS_PER_TURN = 16384
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [DVD_W-1:0]             value,
    output logic                                done,
    output logic [$clog2(COUNTS_PER_TURN)-1:0]  rem
);

    localparam int CW = $clog2(COUNTS_PER_TURN);
    localparam int NW = $clog2(DVD_W);
    localparam bit POW2 = ((COUNTS_PER_TURN & (COUNTS_PER_TURN - 1)) == 0);

    generate
        if (POW2)
        begin : g_mask
            logic          done_reg;
            logic [CW-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            // Two's complement low bits are already the floored remainder.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= value[CW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else
        begin : g_iter
            logic             busy_reg;
            logic             fix_reg;
            logic             done_reg;
            logic [NW-1:0]    cnt_reg;
            logic             neg_reg;
            logic [DVD_W-1:0] dvd_reg;
            logic [CW-1:0]    part_reg;
            logic [CW-1:0]    rem_reg;
            logic [CW:0]      trial;
            logic [CW-1:0]    part_next;

            always_comb
            begin
                trial = {part_reg, dvd_reg[DVD_W-1]};
                if (trial >= (CW+1)'(COUNTS_PER_TURN))
                begin
                    part_next = CW'(trial - (CW+1)'(COUNTS_PER_TURN));
                end
                else
                begin
                    part_next = trial[CW-1:0];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b0;
                    done_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        busy_reg <= 1'b1;
                        cnt_reg  <= NW'(DVD_W - 1);
                    end
                    else if (busy_reg)
                    begin
                        if (cnt_reg == '0)
                        begin
                            busy_reg <= 1'b0;
                            fix_reg  <= 1'b1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                    else if (fix_reg)
                    begin
                        fix_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end

            // Divide the magnitude, then fold a negative remainder back into range.
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    neg_reg  <= value[DVD_W-1];
                    dvd_reg  <= value[DVD_W-1] ? DVD_W'(-value) : DVD_W'(value);
                    part_reg <= '0;
                end
                else if (busy_reg)
                begin
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    part_reg <= part_next;
                end
                else if (fix_reg)
                begin
                    if (neg_reg && (part_reg != '0))
                    begin
                        rem_reg <= CW'(COUNTS_PER_TURN) - part_reg;
                    end
                    else
                    begin
                        rem_reg <= part_reg;
                    end
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

[hw/rtl/encoder_pll_tracker_top.sv]
// Channel  | Handshake                  | Beat contents
// ---------+----------------------------+---------------------------------------------
// config   | psel, penable, pwrite      | paddr, pwdata (32-bit registers at 4*i)
// input    | in_valid / in_stall        | raw_count
// output   | out_valid / out_stall      | wrapped_angle, velocity, continuous_position
//
// The input stays stalled from acceptance until the sequencer returns to idle;
// how long that takes depends on whether COUNTS_PER_TURN is a power of two, on the
// shared 24x25 multiplier (three passes through MUL0, MUL1 and MUL2) and on the
// turn remainder unit, which divides bit by bit for other turn counts.
// Reset is asynchronous and active low; it clears the loop state and the gains.
// The result sits in an output register, so a stalled output beat does not hold
// off the next input; only a second finished result waits for the first.
//
// Depends on epll_pkg, epll_mod and encoder_pll_tracker_top_macros.svh.
`include "encoder_pll_tracker_top_macros.svh"

module encoder_pll_tracker_top
    import epll_pkg::*;
#(
    parameter int unsigned COUNTS_PER_TURN = 16384
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [13:0]         raw_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [29:0]         wrapped_angle,
    output logic signed [31:0]  velocity,
    output logic signed [47:0]  continuous_position
);

    // Turn geometry. Phases are counts in Q16, so one turn is COUNTS_PER_TURN << 16.
    localparam int CW = $clog2(COUNTS_PER_TURN);
    localparam int AW = CW + 16;   // wrapped angle, always below one turn
    localparam int EW = CW + 17;   // signed difference of two angles
    localparam logic signed [EW-1:0] TURN_S = EW'(longint'(COUNTS_PER_TURN) * 65536);
    localparam logic signed [EW-1:0] HALF_S = EW'(longint'(COUNTS_PER_TURN) * 32768);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MODC   = 4'd1;
    localparam logic [3:0] S_ERR    = 4'd2;
    localparam logic [3:0] S_MUL0   = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_INTEG  = 4'd6;
    localparam logic [3:0] S_CMD    = 4'd7;
    localparam logic [3:0] S_DIFF   = 4'd8;
    localparam logic [3:0] S_VEL    = 4'd9;
    localparam logic [3:0] S_POS    = 4'd10;
    localparam logic [3:0] S_PSTART = 4'd11;
    localparam logic [3:0] S_MODP   = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    // Configuration registers.
    logic [15:0] prop_gain_reg;
    logic [23:0] integ_gain_reg;
    logic [28:0] vel_limit_reg;
    logic [15:0] filter_alpha_reg;
    logic [13:0] rel_err_reg;
    logic [13:0] rel_step_reg;

    // Control and loop state.
    logic [3:0]  state_reg, state_next;
    mstep_t      mstep_reg, mstep_next;
    logic        out_valid_reg, out_valid_next;
    logic        started_reg, started_next;
    logic [13:0] last_count_reg, last_count_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [47:0] pos_reg, pos_next;
    logic [AW-1:0]      angle_reg, angle_next;

    // Working registers of one beat.
    logic [13:0]        count_reg, count_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic signed [EW-1:0] step_reg, step_next;
    logic signed [47:0] opd_reg, opd_next;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] icand_reg, icand_next;
    logic signed [29:0] cmd_reg, cmd_next;
    logic               relock_reg, relock_next;

    // Output beat registers.
    logic [29:0]        out_angle_reg, out_angle_next;
    logic signed [31:0] out_vel_reg, out_vel_next;
    logic signed [47:0] out_pos_reg, out_pos_next;

    // Remainder unit hookup.
    logic                     mod_start;
    logic signed [DVD_W-1:0]  mod_value;
    logic                     mod_done;
    logic [CW-1:0]            mod_rem;
    logic [13:0]              new_count;

    // Combinational datapath.
    logic                 cfg_wr;
    logic                 in_take;
    logic                 out_take;
    logic signed [EW-1:0] phase_s, last_phase_s, angle_s;
    logic signed [EW-1:0] err_d, err_w, step_d, step_w;
    logic [EW-1:0]        abs_err, abs_step;
    logic [23:0]          mul_a;
    logic signed [24:0]   mul_b;
    logic signed [49:0]   mul_p;
    logic signed [63:0]   prod_ext;
    logic signed [47:0]   isum, cmd_full, vsum, lim48, neg_lim48;
    logic signed [29:0]   lim_s, neg_lim_s;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign wrapped_angle       = out_angle_reg;
    assign velocity            = out_vel_reg;
    assign continuous_position = out_pos_reg;

    // Register readback.
    always_comb
    begin
        case (paddr[4:2])
            REG_PROP_GAIN:    prdata = 32'(prop_gain_reg);
            REG_INTEG_GAIN:   prdata = 32'(integ_gain_reg);
            REG_VEL_LIMIT:    prdata = 32'(vel_limit_reg);
            REG_FILTER_ALPHA: prdata = 32'(filter_alpha_reg);
            REG_RELOCK_ERR:   prdata = 32'(rel_err_reg);
            REG_RELOCK_STEP:  prdata = 32'(rel_step_reg);
            default:          prdata = '0;
        endcase
    end

    // The remainder unit reduces the raw count on acceptance and the upper
    // 32 bits of the new position once the position has been integrated.
    assign mod_start = in_take || (state_reg == S_PSTART);
    assign mod_value = (state_reg == S_IDLE) ? DVD_W'($signed({1'b0, raw_count}))
                                             : pos_reg[47:16];
    assign new_count = 14'(mod_rem);

    epll_mod #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (mod_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // Phase error against the tracked angle and the measured count step, both
    // wrapped to half a turn.
    always_comb
    begin
        phase_s      = $signed(EW'({count_reg, 16'h0000}));
        last_phase_s = $signed(EW'({last_count_reg, 16'h0000}));
        angle_s      = $signed(EW'(angle_reg));

        err_d = phase_s - angle_s;
        if (err_d > HALF_S)
        begin
            err_w = err_d - TURN_S;
        end
        else if (err_d < -HALF_S)
        begin
            err_w = err_d + TURN_S;
        end
        else
        begin
            err_w = err_d;
        end

        step_d = phase_s - last_phase_s;
        if (step_d > HALF_S)
        begin
            step_w = step_d - TURN_S;
        end
        else if (step_d < -HALF_S)
        begin
            step_w = step_d + TURN_S;
        end
        else
        begin
            step_w = step_d;
        end

        abs_err  = err_reg[EW-1]  ? EW'(-err_reg)  : EW'(err_reg);
        abs_step = step_reg[EW-1] ? EW'(-step_reg) : EW'(step_reg);
    end

    // Shared multiplier: a 24-bit unsigned gain times one 24-bit half of the
    // 48-bit operand; the low half goes first, the high half carries the sign.
    always_comb
    begin
        case (mstep_reg)
            MS_INTEG: mul_a = integ_gain_reg;
            MS_PROP:  mul_a = 24'(prop_gain_reg);
            MS_ALPHA: mul_a = 24'(filter_alpha_reg);
            default:  mul_a = '0;
        endcase
        if (state_reg == S_MUL0)
        begin
            mul_b = $signed({1'b0, opd_reg[23:0]});
        end
        else
        begin
            mul_b = $signed({opd_reg[47], opd_reg[47:24]});
        end
        mul_p    = $signed({1'b0, mul_a}) * mul_b;
        prod_ext = 64'(prod_reg);
    end

    // Loop arithmetic of the single-step states.
    always_comb
    begin
        isum      = $signed({{8{acc_reg[63]}}, acc_reg[63:24]}) + 48'(integ_reg);
        cmd_full  = $signed(acc_reg[63:16]) + 48'(icand_reg);
        vsum      = $signed(acc_reg[63:16]) + 48'(vel_reg);
        lim48     = $signed({19'b0, vel_limit_reg});
        neg_lim48 = -lim48;
        lim_s     = $signed({1'b0, vel_limit_reg});
        neg_lim_s = -lim_s;
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        mstep_next      = mstep_reg;
        out_valid_next  = out_valid_reg;
        started_next    = started_reg;
        last_count_next = last_count_reg;
        integ_next      = integ_reg;
        vel_next        = vel_reg;
        pos_next        = pos_reg;
        angle_next      = angle_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        step_next       = step_reg;
        opd_next        = opd_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        icand_next      = icand_reg;
        cmd_next        = cmd_reg;
        relock_next     = relock_reg;
        out_angle_next  = out_angle_reg;
        out_vel_next    = out_vel_reg;
        out_pos_next    = out_pos_reg;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_MODC;
                end
            end
            S_MODC:
            begin
                if (mod_done)
                begin
                    count_next = new_count;
                    if (!started_reg)
                    begin
                        // First sample only seeds the position; velocity and
                        // integrator keep their values.
                        started_next    = 1'b1;
                        last_count_next = new_count;
                        pos_next        = $signed(48'({new_count, 16'h0000}));
                        angle_next      = AW'({new_count, 16'h0000});
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_ERR;
                    end
                end
            end
            S_ERR:
            begin
                err_next   = err_w;
                step_next  = step_w;
                opd_next   = 48'(err_w);
                mstep_next = MS_INTEG;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                prod_next  = mul_p;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                prod_next  = mul_p;
                acc_next   = prod_ext;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                acc_next = acc_reg + (prod_ext <<< 24);
                case (mstep_reg)
                    MS_INTEG: state_next = S_INTEG;
                    MS_PROP:  state_next = S_CMD;
                    default:  state_next = S_VEL;
                endcase
            end
            S_INTEG:
            begin
                icand_next = sat32(isum);
                mstep_next = MS_PROP;
                state_next = S_MUL0;
            end
            S_CMD:
            begin
                // Clamp the PI command; hold the integrator when the clamp
                // and the error push the same way.
                if (cmd_full > lim48)
                begin
                    cmd_next   = lim_s;
                    integ_next = (err_reg > 0) ? integ_reg : icand_reg;
                end
                else if (cmd_full < neg_lim48)
                begin
                    cmd_next   = neg_lim_s;
                    integ_next = (err_reg < 0) ? integ_reg : icand_reg;
                end
                else
                begin
                    cmd_next   = cmd_full[29:0];
                    integ_next = icand_reg;
                end
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                opd_next    = 48'(cmd_reg) - 48'(vel_reg);
                relock_next = (48'(abs_err) > 48'({rel_err_reg, 16'h0000})) &&
                              (48'(abs_step) < 48'({rel_step_reg, 16'h0000}));
                mstep_next  = MS_ALPHA;
                state_next  = S_MUL0;
            end
            S_VEL:
            begin
                if (relock_reg)
                begin
                    vel_next = sat32(48'(step_reg));
                end
                else
                begin
                    vel_next = sat32(vsum);
                end
                state_next = S_POS;
            end
            S_POS:
            begin
                // Relock snaps onto the measurement; otherwise integrate velocity.
                if (relock_reg)
                begin
                    pos_next = pos_reg + 48'(err_reg);
                end
                else
                begin
                    pos_next = pos_reg + 48'(vel_reg);
                end
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                state_next = S_MODP;
            end
            S_MODP:
            begin
                if (mod_done)
                begin
                    angle_next      = {mod_rem, pos_reg[15:0]};
                    last_count_next = count_reg;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_angle_next = 30'(angle_reg);
                    out_vel_next   = vel_reg;
                    out_pos_next   = pos_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and loop state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            vel_limit_reg    <= '0;
            filter_alpha_reg <= '0;
            rel_err_reg      <= RELOCK_ERR_RST;
            rel_step_reg     <= RELOCK_STEP_RST;
            state_reg        <= S_IDLE;
            mstep_reg        <= MS_INTEG;
            out_valid_reg    <= 1'b0;
            started_reg      <= 1'b0;
            last_count_reg   <= '0;
            integ_reg        <= '0;
            vel_reg          <= '0;
            pos_reg          <= '0;
            angle_reg        <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[4:2])
                    REG_PROP_GAIN:    prop_gain_reg    <= pwdata[15:0];
                    REG_INTEG_GAIN:   integ_gain_reg   <= pwdata[23:0];
                    REG_VEL_LIMIT:    vel_limit_reg    <= pwdata[28:0];
                    REG_FILTER_ALPHA: filter_alpha_reg <= pwdata[15:0];
                    REG_RELOCK_ERR:   rel_err_reg      <= pwdata[13:0];
                    REG_RELOCK_STEP:  rel_step_reg     <= pwdata[13:0];
                    default:          ;
                endcase
            end
            state_reg      <= state_next;
            mstep_reg      <= mstep_next;
            out_valid_reg  <= out_valid_next;
            started_reg    <= started_next;
            last_count_reg <= last_count_next;
            integ_reg      <= integ_next;
            vel_reg        <= vel_next;
            pos_reg        <= pos_next;
            angle_reg      <= angle_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        count_reg     <= count_next;
        err_reg       <= err_next;
        step_reg      <= step_next;
        opd_reg       <= opd_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        icand_reg     <= icand_next;
        cmd_reg       <= cmd_next;
        relock_reg    <= relock_next;
        out_angle_reg <= out_angle_next;
        out_vel_reg   <= out_vel_next;
        out_pos_reg   <= out_pos_next;
    end

    // An accepted beat keeps the input stalled while it is worked on.
    `EPT_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "input not stalled after accept")
    // The clamped command never leaves the velocity limit.
    `EPT_ASSERT_SAME(a_cmd_clamped, state_reg == S_DIFF,
        cmd_reg <= lim_s && cmd_reg >= neg_lim_s, "command outside velocity limit")
    // The remainder unit only answers while the sequencer waits for it.
    `EPT_ASSERT_SAME(a_mod_done_waited, mod_done,
        state_reg == S_MODC || state_reg == S_MODP, "remainder done while not waiting")

endmodule

[tb/testbench.sv]
// Self-checking testbench for the encoder phase-locked-loop tracker.
// Needs epll_pkg and encoder_pll_tracker_top; it builds its own stimulus and
// predicts untyped output beats with an independent fixed-point loop model.
module testbench;
    import epll_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNTS_PER_TURN = 16384;
    localparam longint TURN_Q16 = longint'(COUNTS_PER_TURN) * 65536;

    // Settle time after the last expected beat, so that the block is idle again.
    localparam int SETTLE_CYCLES = 100;
    localparam int JAM_CYCLES = 300;
    localparam int SEGMENTS = 19;
    localparam int ITEMS_PER_SEGMENT = 100;
    localparam longint WATCHDOG_NS = 64'd20_000_000;

    // The register map has six entries; index seven decodes to nothing.
    localparam reg_idx_t BAD_REG = 3'd7;

    localparam longint ANGLE_16383 = 16383 * 65536;
    localparam longint ANGLE_8193 = 8193 * 65536;
    localparam longint ANGLE_8194 = 8194 * 65536;
    localparam longint ONE_COUNT = 65536;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One output beat: angle within the turn, velocity and unwrapped position.
    typedef struct {
        logic [29:0]        wa;
        logic signed [31:0] vel;
        logic signed [47:0] pos;
    } track_beat_t;

    // A directed row either writes a register or sends one encoder count. Rows
    // marked known carry the expected beat typed in; the rest are predicted.
    typedef struct {
        row_kind_e          kind;
        reg_idx_t           idx;
        logic [31:0]        value;
        logic [13:0]        count;
        bit                 known;
        logic [29:0]        wa;
        logic signed [31:0] vel;
        logic signed [47:0] pos;
    } stim_row_t;

    localparam int PLAN_LEN = 28;

    stim_row_t plan [PLAN_LEN] = '{
        // With all gains at their reset value of zero the first sample seeds the
        // position; only relock, or the velocity that relock leaves, can move it afterwards.
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd16383, 1'b1,
          30'(ANGLE_16383), 32'sd0, 48'(ANGLE_16383)},
        // Crossing zero is an error of one count, far below the relock threshold.
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd0, 1'b1,
          30'(ANGLE_16383), 32'sd0, 48'(ANGLE_16383)},
        // A step of exactly half a turn is large, so relock does not fire.
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd8192, 1'b1,
          30'(ANGLE_16383), 32'sd0, 48'(ANGLE_16383)},
        // Large error with a one-count step snaps the position to the count.
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd8193, 1'b1,
          30'(ANGLE_8193), 32'(ONE_COUNT), 48'(ANGLE_8193)},
        // Zero filter coefficient holds the relock velocity, which keeps integrating.
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd8193, 1'b1,
          30'(ANGLE_8194), 32'(ONE_COUNT), 48'(ANGLE_8194)},
        // Every gain at its top value, relock on any error with a small step.
        '{ROW_CFG, REG_VEL_LIMIT, 32'd536870911, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_PROP_GAIN, 32'd65535, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_INTEG_GAIN, 32'd16777215, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_FILTER_ALPHA, 32'd65535, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_RELOCK_ERR, 32'd0, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_RELOCK_STEP, 32'd8192, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd16383, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd8192, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd4096, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd12288, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd12289, 1'b0, '0, '0, '0},
        // A write outside the register map must leave every register alone.
        '{ROW_CFG, BAD_REG, 32'hFFFF_FFFF, 14'd0, 1'b0, '0, '0, '0},
        // Zero velocity clamp: every nonzero command clamps and may hold the integrator.
        '{ROW_CFG, REG_VEL_LIMIT, 32'd0, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_PROP_GAIN, 32'd0, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_FILTER_ALPHA, 32'd1, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_RELOCK_ERR, 32'd8192, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_CFG, REG_RELOCK_STEP, 32'd0, 14'd0, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd1000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd3000, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd9192, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd9192, 1'b0, '0, '0, '0},
        '{ROW_ITEM, REG_PROP_GAIN, 32'd0, 14'd1, 1'b0, '0, '0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [13:0] raw_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [29:0] wrapped_angle;
    logic signed [31:0] velocity;
    logic signed [47:0] continuous_position;

    // Shared pacing controls: quiet turns idling off on both sides, and jam_req
    // asks the receiver for one long hold-off.
    bit quiet = 1'b0;
    bit jam_req = 1'b0;

    int mismatch_count = 0;
    track_beat_t expected_track [$];

    // Mirror of the register file, reset values included.
    longint prop_k = 0;
    longint integ_k = 0;
    longint vel_cap = 0;
    longint alpha_k = 0;
    longint relock_err_cnt = longint'(RELOCK_ERR_RST);
    longint relock_step_cnt = longint'(RELOCK_STEP_RST);

    // Loop state of the predictor.
    bit seeded = 1'b0;
    logic [13:0] prev_count = '0;
    longint integ_acc = 0;
    longint vel_est = 0;
    longint pos_est = 0;

    encoder_pll_tracker_top #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .raw_count           (raw_count),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .wrapped_angle       (wrapped_angle),
        .velocity            (velocity),
        .continuous_position (continuous_position)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Keeps the low 48 bits and sign-extends them again.
    function automatic longint to_pos48(input longint x);
        logic signed [47:0] t;
        t = x[47:0];
        return longint'(t);
    endfunction

    // Position modulo one turn, always in [0, TURN_Q16).
    function automatic longint turn_angle(input longint x);
        longint r;
        r = x % TURN_Q16;
        if (r < 0)
        begin
            r += TURN_Q16;
        end
        return r;
    endfunction

    // Folds a phase difference into [-half turn, +half turn]; exactly half a
    // turn either way is left as it is.
    function automatic longint to_half_turn(input longint x);
        if (x > TURN_Q16 / 2)
        begin
            return x - TURN_Q16;
        end
        if (x < -(TURN_Q16 / 2))
        begin
            return x + TURN_Q16;
        end
        return x;
    endfunction

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Advances the loop by one encoder count and returns the beat it produces.
    // Arithmetic right shifts of the signed products round toward minus infinity.
    function automatic track_beat_t track_step(input logic [13:0] count);
        longint phase;
        longint err;
        longint integ_new;
        longint cmd;
        longint vel_new;
        longint pos_new;
        longint stride;
        track_beat_t r;
        phase = (longint'(count) % longint'(COUNTS_PER_TURN)) * 65536;
        if (!seeded)
        begin
            // The first sample only seeds the position; velocity is reported as is.
            seeded = 1'b1;
            prev_count = count;
            pos_est = to_pos48(phase);
            r.wa = 30'(turn_angle(pos_est));
            r.vel = 32'(vel_est);
            r.pos = 48'(pos_est);
            return r;
        end
        err = to_half_turn(phase - turn_angle(pos_est));
        integ_new = clamp32(integ_acc + ((integ_k * err) >>> 24));
        cmd = ((prop_k * err) >>> 16) + integ_new;
        // Anti-windup: when the command clamps in the direction the error
        // pushes, the integrator keeps its old value.
        if (cmd > vel_cap)
        begin
            cmd = vel_cap;
            if (err > 0)
            begin
                integ_new = integ_acc;
            end
        end
        else if (cmd < -vel_cap)
        begin
            cmd = -vel_cap;
            if (err < 0)
            begin
                integ_new = integ_acc;
            end
        end
        integ_acc = integ_new;
        vel_new = clamp32(vel_est + ((alpha_k * (cmd - vel_est)) >>> 16));
        pos_new = to_pos48(pos_est + vel_new);
        // Relock: a large error while the count barely moved means the estimate
        // has lost the shaft, so jump to the measurement.
        stride = to_half_turn(phase - (longint'(prev_count) % longint'(COUNTS_PER_TURN)) * 65536);
        if (magnitude(err) > relock_err_cnt * 65536 &&
            magnitude(stride) < relock_step_cnt * 65536)
        begin
            pos_new = to_pos48(pos_est + err);
            vel_new = clamp32(stride);
        end
        vel_est = vel_new;
        pos_est = pos_new;
        prev_count = count;
        r.wa = 30'(turn_angle(pos_new));
        r.vel = 32'(vel_new);
        r.pos = 48'(pos_new);
        return r;
    endfunction

    // Mostly short gaps, some medium ones that land inside the block's work,
    // and a few long ones.
    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(99, 0);
        if (roll < 45)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(25, 1);
        end
        return $urandom_range(80, 30);
    endfunction

    // Offers one count after an optional gap and waits until the block takes
    // it. The expected beat is queued at the acceptance edge, so the queue
    // order follows the order in which beats enter the block.
    task automatic push_sample(input logic [13:0] count, input int unsigned gap,
                               input bit known, input track_beat_t typed);
        track_beat_t predicted;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_count <= count;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predicted = track_step(count);
        expected_track.push_back(known ? typed : predicted);
    endtask

    // Stops offering beats and waits until every expected beat has come out,
    // plus the settle time, so that a register write finds it idle.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_track.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. The mirror is
    // updated the same way the block decodes the address.
    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PROP_GAIN:    prop_k = longint'(value[15:0]);
            REG_INTEG_GAIN:   integ_k = longint'(value[23:0]);
            REG_VEL_LIMIT:    vel_cap = longint'(value[28:0]);
            REG_FILTER_ALPHA: alpha_k = longint'(value[15:0]);
            REG_RELOCK_ERR:   relock_err_cnt = longint'(value[13:0]);
            REG_RELOCK_STEP:  relock_step_cnt = longint'(value[13:0]);
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Every accepted output beat is compared with the oldest expectation.
    always @(posedge clk)
    begin : track_check
        track_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_track.size() == 0)
            begin
                $error("output beat with nothing expected: angle %0d velocity %0d position %0d",
                       wrapped_angle, velocity, continuous_position);
                mismatch_count++;
            end
            else
            begin
                want = expected_track.pop_front();
                if (wrapped_angle !== want.wa)
                begin
                    $error("wrapped_angle: expected %0d, got %0d", want.wa, wrapped_angle);
                    mismatch_count++;
                end
                if (velocity !== want.vel)
                begin
                    $error("velocity: expected %0d, got %0d", want.vel, velocity);
                    mismatch_count++;
                end
                if (continuous_position !== want.pos)
                begin
                    $error("continuous_position: expected %0d, got %0d",
                           want.pos, continuous_position);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver pacing. Random stalls unless quiet is set, and on request one
    // long hold-off so that the output register and the finished result behind
    // it both fill up and the block has to stall its input.
    initial
    begin : sink_pacing
        int unsigned hold;
        forever
        begin
            @(posedge clk);
            if (jam_req)
            begin
                out_stall <= 1'b1;
                repeat (JAM_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                jam_req = 1'b0;
            end
            else if (!quiet && $urandom_range(3, 0) == 0)
            begin
                hold = gap_len();
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin : stimulus
        track_beat_t typed;
        track_beat_t blank;
        reg_idx_t idx;
        logic [31:0] top;
        logic [31:0] tuned_lo;
        logic [31:0] tuned_hi;
        logic [31:0] setting;
        logic [13:0] count;
        bit tuned;
        int unsigned pick;
        int unsigned roll;
        longint speed_cap;
        longint speed_q8;
        longint shaft_q8;
        longint jitter;

        blank = '{default: '0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table. Register rows wait for an idle block.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_pipeline();
                reg_write(plan[i].idx, plan[i].value);
            end
            else
            begin
                typed.wa = plan[i].wa;
                typed.vel = plan[i].vel;
                typed.pos = plan[i].pos;
                push_sample(plan[i].count, gap_len(), plan[i].known, typed);
            end
        end

        // Random part: each segment picks new settings, then follows a simulated
        // shaft at some speed, with jitter, holds, sudden jumps (which provoke
        // relock) and a share of pure noise counts.
        shaft_q8 = longint'($urandom_range(COUNTS_PER_TURN - 1, 0)) << 8;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_pipeline();
            tuned = $urandom_range(2, 0) != 0;
            for (int r = REG_PROP_GAIN; r <= REG_RELOCK_STEP; r++)
            begin
                idx = reg_idx_t'(r);
                case (idx)
                    REG_PROP_GAIN:
                    begin
                        top = 32'd65535;
                        tuned_lo = 32'd8000;
                        tuned_hi = 32'd40000;
                    end
                    REG_INTEG_GAIN:
                    begin
                        top = 32'd16777215;
                        tuned_lo = 32'd1000;
                        tuned_hi = 32'd400000;
                    end
                    REG_VEL_LIMIT:
                    begin
                        top = 32'd536870911;
                        tuned_lo = 32'd67108864;
                        tuned_hi = 32'd536870911;
                    end
                    REG_FILTER_ALPHA:
                    begin
                        top = 32'd65535;
                        tuned_lo = 32'd16384;
                        tuned_hi = 32'd65535;
                    end
                    REG_RELOCK_ERR:
                    begin
                        top = 32'd8192;
                        tuned_lo = 32'd1500;
                        tuned_hi = 32'd4000;
                    end
                    default:
                    begin
                        top = 32'd8192;
                        tuned_lo = 32'd100;
                        tuned_hi = 32'd600;
                    end
                endcase
                pick = $urandom_range(9, 0);
                if (pick == 0)
                begin
                    setting = '0;
                end
                else if (pick == 1)
                begin
                    setting = top;
                end
                else if (tuned)
                begin
                    setting = $urandom_range(tuned_hi, tuned_lo);
                end
                else
                begin
                    setting = $urandom_range(top, 0);
                end
                reg_write(idx, setting);
            end

            // Slow, moderate or near half-turn-per-sample shafts.
            case ($urandom_range(2, 0))
                0:       speed_cap = 40;
                1:       speed_cap = 1500;
                default: speed_cap = 8000;
            endcase
            speed_q8 = longint'($urandom_range(2 * speed_cap * 256, 0)) - speed_cap * 256;

            for (int k = 0; k < ITEMS_PER_SEGMENT; k++)
            begin
                if (k % 25 == 0)
                begin
                    quiet = $urandom_range(3, 0) == 0;
                end
                if (k == 50 && !jam_req && (seg == 0 || $urandom_range(3, 0) == 0))
                begin
                    jam_req = 1'b1;
                end
                roll = $urandom_range(99, 0);
                if (roll < 8)
                begin
                    count = 14'($urandom_range(COUNTS_PER_TURN - 1, 0));
                end
                else
                begin
                    if (roll < 12)
                    begin
                        shaft_q8 += longint'($urandom_range(COUNTS_PER_TURN - 1, 0)) << 8;
                    end
                    else if (roll >= 15)
                    begin
                        if (roll >= 95)
                        begin
                            speed_q8 += longint'($urandom_range(512, 0)) - 256;
                        end
                        shaft_q8 += speed_q8;
                    end
                    jitter = (roll % 3 == 0) ? longint'($urandom_range(4, 0)) - 2 : 0;
                    count = 14'((shaft_q8 >>> 8) + jitter);
                end
                push_sample(count, quiet ? 0 : gap_len(), 1'b0, blank);
            end
        end

        quiet = 1'b0;
        drain_pipeline();
        if (mismatch_count == 0)
        begin
            $display("[encoder_pll_tracker_top] OK");
        end
        else
        begin
            $display("[encoder_pll_tracker_top] ERROR");
        end
        $finish;
    end

    // Hard stop in case the block hangs or loses a beat.
    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("[encoder_pll_tracker_top] ERROR");
        $finish;
    end

endmodule
